// File: rtl/srag_pkg.sv
`timescale 1ns / 1ps

package srag_pkg;

  localparam int BoardSide = 8;
  localparam int BoardLast = 7;
  localparam int RayCount  = 4;

  typedef enum logic [1:0] {
    OP_ROOK        = 2'd0,
    OP_BISHOP      = 2'd1,
    OP_ROOK_XRAY   = 2'd2,
    OP_BISHOP_XRAY = 2'd3
  } op_t;

  typedef logic signed [1:0] step_t;

  // Orthogonal rays first, then diagonal rays.
  localparam step_t STEP_RANK [2*RayCount] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                               2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam step_t STEP_FILE [2*RayCount] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                               2'sd1, -2'sd1, 2'sd1, -2'sd1};

endpackage

// File: rtl/srag_ray_unit.sv
`timescale 1ns / 1ps

module srag_ray_unit
  import srag_pkg::*;
(
  input  logic [5:0]  square,
  input  logic [63:0] occupancy,
  input  logic        diag,
  output logic [63:0] attack
);

  always_comb begin
    logic signed [4:0] r;
    logic signed [4:0] f;
    logic              open;
    logic [5:0]        idx;
    step_t             dr;
    step_t             df;
    attack = '0;
    for (int d = 0; d < RayCount; d++) begin
      dr   = diag ? STEP_RANK[d + RayCount] : STEP_RANK[d];
      df   = diag ? STEP_FILE[d + RayCount] : STEP_FILE[d];
      r    = $signed({2'b00, square[5:3]});
      f    = $signed({2'b00, square[2:0]});
      open = 1'b1;
      for (int k = 0; k < BoardLast; k++) begin
        r = r + 5'(dr);
        f = f + 5'(df);
        idx = {r[2:0], f[2:0]};
        if (open && r >= 5'sd0 && r <= 5'(BoardLast) && f >= 5'sd0
            && f <= 5'(BoardLast)) begin
          attack[idx] = 1'b1;
          if (occupancy[idx]) begin
            open = 1'b0;
          end
        end else begin
          open = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/sliding_ray_attack_generator_core.sv
`timescale 1ns / 1ps
// An accepted word passes through the s0 input registers and the s1 registers into the
// result register, where it is shown for one cycle with out_valid high for the receiver.
// Throughput: one word per cycle; busy is held low, as the receiver cannot stall.
// The two ray passes of the x-ray modes sit in separate pipeline stages.
// Reset (rst_n low, synchronous) clears the stage valid flags only.

module sliding_ray_attack_generator_core
  import srag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_square,
  input  logic [63:0] in_occupancy,
  input  logic [63:0] in_xray_blockers,
  output logic        out_valid,
  output logic [63:0] out_attack_map
);

  logic        s0_valid_r;
  op_t         s0_op_r;
  logic [5:0]  s0_square_r;
  logic [63:0] s0_occ_r;
  logic [63:0] s0_blk_r;

  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [5:0]  s1_square_r;
  logic [63:0] s1_occ_r;
  logic [63:0] s1_blk_r;
  logic [63:0] s1_att_r;

  logic        out_valid_r;
  logic [63:0] out_map_r;

  logic        s0_diag;
  logic        s1_diag;
  logic        s1_xray;
  logic [63:0] s0_att;
  logic [63:0] s1_att;
  logic [63:0] s1_occ2;
  logic [63:0] out_map_nxt;

  assign busy = 1'b0;

  assign s0_diag = (s0_op_r == OP_BISHOP) || (s0_op_r == OP_BISHOP_XRAY);
  assign s1_diag = (s1_op_r == OP_BISHOP) || (s1_op_r == OP_BISHOP_XRAY);
  assign s1_xray = (s1_op_r == OP_ROOK_XRAY) || (s1_op_r == OP_BISHOP_XRAY);

  srag_ray_unit u_first (
    .square    (s0_square_r),
    .occupancy (s0_occ_r),
    .diag      (s0_diag),
    .attack    (s0_att)
  );

  // Blockers that the first pass reaches are toggled out of the occupancy.
  assign s1_occ2 = s1_occ_r ^ (s1_blk_r & s1_att_r);

  srag_ray_unit u_second (
    .square    (s1_square_r),
    .occupancy (s1_occ2),
    .diag      (s1_diag),
    .attack    (s1_att)
  );

  assign out_map_nxt = s1_xray ? (s1_att_r ^ s1_att) : s1_att_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= start && !busy;
      s1_valid_r  <= s0_valid_r;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_op_r     <= op_t'(in_op);
    s0_square_r <= in_square;
    s0_occ_r    <= in_occupancy;
    s0_blk_r    <= in_xray_blockers;
    s1_op_r     <= s0_op_r;
    s1_square_r <= s0_square_r;
    s1_occ_r    <= s0_occ_r;
    s1_blk_r    <= s0_blk_r;
    s1_att_r    <= s0_att;
    out_map_r   <= out_map_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_attack_map = out_map_r;

endmodule
